>>> rtl/ihq_pkg.sv
// Shared types and constants for the indirect max-heap priority queue.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ihq_pkg;

    // Default sizing handed to the top level
    localparam int SLOT_COUNT_DEF  = 256;
    localparam int WEIGHT_BITS_DEF = 32;

    // Fixed field widths of the channels
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_BITS     = 8;
    localparam int IN_WT_BITS   = 32;
    localparam int COUNT_BITS   = 9;

    // Request codes
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_BUILD  = 2'd2,
        REQ_REMOVE = 2'd3
    } req_type_t;

    // Status codes returned with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

>>> rtl/ihq_req_if.sv
// Request channel of the heap queue: valid/ready handshake plus payload.
// Depends on ihq_pkg for the request code type and field widths.
`default_nettype none

interface ihq_req_if;
    logic                                 valid;
    logic                                 ready;
    ihq_pkg::req_type_t                   req_type;
    logic [ihq_pkg::SYM_BITS-1:0]         symbol;
    logic signed [ihq_pkg::IN_WT_BITS-1:0] weight;

    modport source (output valid, req_type, symbol, weight, input ready);
    modport sink   (input valid, req_type, symbol, weight, output ready);
endinterface

`default_nettype wire

>>> rtl/ihq_res_if.sv
// Result channel of the heap queue: valid/ready handshake plus payload.
// Depends on ihq_pkg for the status code type and field widths.
`default_nettype none

interface ihq_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [ihq_pkg::SYM_BITS-1:0]          out_symbol;
    logic signed [ihq_pkg::IN_WT_BITS-1:0] out_weight;
    logic [ihq_pkg::COUNT_BITS-1:0]        entry_count;
    ihq_pkg::status_t                      status;

    modport source (output valid, out_symbol, out_weight, entry_count, status, input ready);
    modport sink   (input valid, out_symbol, out_weight, entry_count, status, output ready);
endinterface

`default_nettype wire

>>> rtl/indirect_max_heap_queue_top.sv
// Indirect binary max-heap queue. Slots hold symbol numbers and each symbol's
// signed key sits in a separate weight table; both live in synchronous RAMs.
// Depends on ihq_pkg, ihq_req_if, ihq_res_if and ihq_ram.
//
// One request is worked at a time and each gives exactly one result. Every
// heap level visited is worked as a slot read, a weight read, and a compare
// with write back. Append, a refused append or insert, removal from an empty
// heap and build on fewer than two entries go straight to the finish step;
// insert climbs from the new last slot, remove-max sinks from the root, and
// build sinks each internal slot in turn, from the last one down to the root.
// A result still held on the result channel stretches the finish step until
// it is taken; the new request is taken while the previous result still
// waits there.
`default_nettype none

module indirect_max_heap_queue_top #(
    parameter int SLOT_COUNT  = ihq_pkg::SLOT_COUNT_DEF,
    parameter int WEIGHT_BITS = ihq_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ihq_req_if.sink   req,
    ihq_res_if.source res
);

    import ihq_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int CW = AW + 2;
    localparam int WB = WEIGHT_BITS;
    localparam int SA = $clog2(SYMBOL_COUNT);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_REM_A    = 15'b000000000000010,
        S_REM_B    = 15'b000000000000100,
        S_REM_C    = 15'b000000000001000,
        S_BLD_A    = 15'b000000000010000,
        S_BLD_B    = 15'b000000000100000,
        S_BLD_C    = 15'b000000001000000,
        S_SINK_A   = 15'b000000010000000,
        S_SINK_B   = 15'b000000100000000,
        S_SINK_C   = 15'b000001000000000,
        S_SINK_END = 15'b000010000000000,
        S_RISE_A   = 15'b000100000000000,
        S_RISE_B   = 15'b001000000000000,
        S_RISE_C   = 15'b010000000000000,
        S_FINISH   = 15'b100000000000000
    } state_t;

    // Control state
    state_t  state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    logic    build_reg, build_next;
    logic    res_valid_reg, res_valid_next;

    // Working payload
    logic [AW-1:0]        hole_reg, hole_next;
    logic [AW-1:0]        bidx_reg, bidx_next;
    logic [SYM_BITS-1:0]  mov_sym_reg, mov_sym_next;
    logic signed [WB-1:0] mov_key_reg, mov_key_next;
    logic [SYM_BITS-1:0]  top_sym_reg, top_sym_next;
    logic [SYM_BITS-1:0]  csym0_reg, csym0_next;
    logic [SYM_BITS-1:0]  csym1_reg, csym1_next;
    logic [SYM_BITS-1:0]  psym_reg, psym_next;
    logic [SYM_BITS-1:0]  rsym_reg, rsym_next;
    logic [WB-1:0]        rwt_reg, rwt_next;
    status_t              rstat_reg, rstat_next;

    // Result register
    logic [SYM_BITS-1:0]   res_sym_reg;
    logic [IN_WT_BITS-1:0] res_wt_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;
    status_t               res_stat_reg;
    logic                  res_load;

    // Memory ports
    logic                slot_we;
    logic [AW-1:0]       slot_waddr, slot_ra0, slot_ra1;
    logic [SYM_BITS-1:0] slot_wdata, slot_rd0, slot_rd1;
    logic                wt_we;
    logic [SA-1:0]       wt_waddr, wt_ra0, wt_ra1;
    logic [WB-1:0]       wt_wdata, wt_rd0, wt_rd1;

    // Derived values
    logic signed [WB-1:0] w_in;
    logic signed [WB-1:0] key0, key1;
    logic [CW-1:0]        c_idx, c1_idx, cnt_ext;
    logic                 left_ok, right_ok;
    logic [AW-1:0]        parent;

    ihq_ram #(.WIDTH(SYM_BITS), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk     (clk),
        .we      (slot_we),
        .waddr   (slot_waddr),
        .wdata   (slot_wdata),
        .raddr_a (slot_ra0),
        .rdata_a (slot_rd0),
        .raddr_b (slot_ra1),
        .rdata_b (slot_rd1)
    );

    ihq_ram #(.WIDTH(WB), .DEPTH(SYMBOL_COUNT)) u_weight_ram (
        .clk     (clk),
        .we      (wt_we),
        .waddr   (wt_waddr),
        .wdata   (wt_wdata),
        .raddr_a (wt_ra0),
        .rdata_a (wt_rd0),
        .raddr_b (wt_ra1),
        .rdata_b (wt_rd1)
    );

    // Resize the incoming key to the stored key width
    assign w_in = WB'(req.weight);

    assign key0 = signed'(wt_rd0);
    assign key1 = signed'(wt_rd1);

    // Child and parent positions of the current hole
    assign c_idx    = {1'b0, hole_reg, 1'b1};
    assign c1_idx   = c_idx + CW'(1);
    assign cnt_ext  = CW'(count_reg);
    assign left_ok  = c_idx < cnt_ext;
    assign right_ok = c1_idx < cnt_ext;
    assign parent   = (hole_reg - AW'(1)) >> 1;

    assign req.ready = (state_reg == S_IDLE);

    // Sequencer: walk the heap one level at a time
    always_comb
    begin
        logic                 pick_r;
        logic signed [WB-1:0] ckey;
        logic [SYM_BITS-1:0]  csym;
        logic [CW-1:0]        cidx;

        state_next   = state_reg;
        count_next   = count_reg;
        build_next   = build_reg;
        hole_next    = hole_reg;
        bidx_next    = bidx_reg;
        mov_sym_next = mov_sym_reg;
        mov_key_next = mov_key_reg;
        top_sym_next = top_sym_reg;
        csym0_next   = csym0_reg;
        csym1_next   = csym1_reg;
        psym_next    = psym_reg;
        rsym_next    = rsym_reg;
        rwt_next     = rwt_reg;
        rstat_next   = rstat_reg;
        res_load     = 1'b0;

        slot_we    = 1'b0;
        slot_waddr = hole_reg;
        slot_wdata = mov_sym_reg;
        slot_ra0   = '0;
        slot_ra1   = '0;
        wt_we      = 1'b0;
        wt_waddr   = req.symbol;
        wt_wdata   = w_in;
        wt_ra0     = '0;
        wt_ra1     = '0;

        pick_r = right_ok && (key1 > key0);
        ckey   = pick_r ? key1 : key0;
        csym   = pick_r ? csym1_reg : csym0_reg;
        cidx   = pick_r ? c1_idx : c_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    build_next = 1'b0;
                    rstat_next = ST_OK;
                    rsym_next  = '0;
                    rwt_next   = '0;
                    case (req.req_type) inside
                        REQ_APPEND, REQ_INSERT:
                        begin
                            if (count_reg >= NW'(SLOT_COUNT))
                            begin
                                rstat_next = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                // Store the key; append also places the symbol at the end
                                wt_we        = 1'b1;
                                slot_we      = (req.req_type == REQ_APPEND);
                                slot_waddr   = count_reg[AW-1:0];
                                slot_wdata   = req.symbol;
                                count_next   = count_reg + NW'(1);
                                hole_next    = count_reg[AW-1:0];
                                mov_sym_next = req.symbol;
                                mov_key_next = w_in;
                                state_next   = (req.req_type == REQ_APPEND) ? S_FINISH
                                                                            : S_RISE_A;
                            end
                        end
                        REQ_BUILD:
                        begin
                            if (count_reg <= NW'(1))
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                build_next = 1'b1;
                                bidx_next  = AW'((count_reg >> 1) - NW'(1));
                                state_next = S_BLD_A;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_REM_A;
                            end
                        end
                    endcase
                end
            end

            // Fetch root and last slot
            S_REM_A:
            begin
                slot_ra0   = '0;
                slot_ra1   = AW'(count_reg - NW'(1));
                state_next = S_REM_B;
            end

            S_REM_B:
            begin
                top_sym_next = slot_rd0;
                mov_sym_next = slot_rd1;
                wt_ra0       = slot_rd0;
                wt_ra1       = slot_rd1;
                state_next   = S_REM_C;
            end

            // Capture the removed entry, move last slot into the root hole
            S_REM_C:
            begin
                rsym_next    = top_sym_reg;
                rwt_next     = wt_rd0;
                mov_key_next = key1;
                count_next   = count_reg - NW'(1);
                hole_next    = '0;
                state_next   = S_SINK_A;
            end

            // Lift the entry of the next internal slot for build
            S_BLD_A:
            begin
                slot_ra0   = bidx_reg;
                state_next = S_BLD_B;
            end

            S_BLD_B:
            begin
                mov_sym_next = slot_rd0;
                wt_ra0       = slot_rd0;
                state_next   = S_BLD_C;
            end

            S_BLD_C:
            begin
                mov_key_next = key0;
                hole_next    = bidx_reg;
                state_next   = S_SINK_A;
            end

            // Sift down: read both children or settle the moving entry
            S_SINK_A:
            begin
                if (left_ok)
                begin
                    slot_ra0   = c_idx[AW-1:0];
                    slot_ra1   = right_ok ? c1_idx[AW-1:0] : c_idx[AW-1:0];
                    state_next = S_SINK_B;
                end
                else
                begin
                    slot_we    = 1'b1;
                    state_next = S_SINK_END;
                end
            end

            S_SINK_B:
            begin
                csym0_next = slot_rd0;
                csym1_next = slot_rd1;
                wt_ra0     = slot_rd0;
                wt_ra1     = slot_rd1;
                state_next = S_SINK_C;
            end

            // Pick the larger child, left on a tie; advance only on strict less
            S_SINK_C:
            begin
                slot_we = 1'b1;
                if (mov_key_reg < ckey)
                begin
                    slot_wdata = csym;
                    hole_next  = cidx[AW-1:0];
                    state_next = S_SINK_A;
                end
                else
                begin
                    state_next = S_SINK_END;
                end
            end

            S_SINK_END:
            begin
                if (build_reg && (bidx_reg != '0))
                begin
                    bidx_next  = bidx_reg - AW'(1);
                    state_next = S_BLD_A;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // Sift up: settle at the root or read the parent
            S_RISE_A:
            begin
                if (hole_reg == '0)
                begin
                    slot_we    = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    slot_ra0   = parent;
                    state_next = S_RISE_B;
                end
            end

            S_RISE_B:
            begin
                psym_next  = slot_rd0;
                wt_ra0     = slot_rd0;
                state_next = S_RISE_C;
            end

            S_RISE_C:
            begin
                slot_we = 1'b1;
                if (mov_key_reg > key0)
                begin
                    slot_wdata = psym_reg;
                    hole_next  = parent;
                    state_next = S_RISE_A;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // Hand the result over once the output register is free
            S_FINISH:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold or drop the pending result transaction
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            build_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            build_reg     <= build_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hole_reg    <= hole_next;
        bidx_reg    <= bidx_next;
        mov_sym_reg <= mov_sym_next;
        mov_key_reg <= mov_key_next;
        top_sym_reg <= top_sym_next;
        csym0_reg   <= csym0_next;
        csym1_reg   <= csym1_next;
        psym_reg    <= psym_next;
        rsym_reg    <= rsym_next;
        rwt_reg     <= rwt_next;
        rstat_reg   <= rstat_next;
        if (res_load)
        begin
            res_sym_reg  <= rsym_reg;
            res_wt_reg   <= IN_WT_BITS'(rwt_reg);
            res_cnt_reg  <= COUNT_BITS'(count_reg);
            res_stat_reg <= rstat_reg;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.out_symbol  = res_sym_reg;
    assign res.out_weight  = signed'(res_wt_reg);
    assign res.entry_count = res_cnt_reg;
    assign res.status      = res_stat_reg;

endmodule

`default_nettype wire

>>> rtl/ihq_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies; used for the slot table and the weight table.
`default_nettype none

module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output      logic [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output      logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire
